// ===== sv/sparse_nearest_neighbor_expand_macros.svh =====
// Assertion macros used by the checker file.
`ifndef SPARSE_NEAREST_NEIGHBOR_EXPAND_MACROS_SVH
`define SPARSE_NEAREST_NEIGHBOR_EXPAND_MACROS_SVH

// Check a consequence in the cycle after a condition, ignored while reset is high.
`define SNNE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Same check without a reset exemption, for the reset behavior itself.
`define SNNE_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/snne_pkg.sv =====
package snne_pkg;

  // Fraction bits of the scale registers, longest run side, index width.
  localparam int SCALE_FRAC_BITS = 16;
  localparam int MAX_SPAN        = 8;
  localparam int INDEX_BITS      = 32;

  // Fixed field widths.
  localparam int FIELD_W    = 32;
  localparam int SCALE_W    = 20;
  localparam int VALUE_W    = 64;
  localparam int DATA_W     = 2 * FIELD_W + VALUE_W;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;

  // Derived widths.
  localparam int PROD_W = INDEX_BITS + 1 + SCALE_W;
  localparam int CEIL_W = PROD_W - SCALE_FRAC_BITS;
  localparam int CNT_W  = $clog2(MAX_SPAN + 1);

  // Run queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_SCALE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_SCALE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_ROWS  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_COLS  = 2'd3;

  // Reset values of the registers.
  localparam logic [SCALE_W-1:0]    SCALE_RESET = 20'd65536;
  localparam logic [CFG_DATA_W-1:0] SIZE_RESET  = 32'd1;

  // One run of destination cells: first row and column, counts and value.
  typedef struct packed {
    logic [INDEX_BITS-1:0] row_first;
    logic [CNT_W-1:0]      row_cnt;
    logic [INDEX_BITS-1:0] col_first;
    logic [CNT_W-1:0]      col_cnt;
    logic [VALUE_W-1:0]    value;
  } run_t;

  // Queue status seen by the two sides.
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

// ===== sv/snne_front.sv =====
module snne_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [snne_pkg::DATA_W-1:0]       s_axis_tdata,
  input  logic [snne_pkg::SCALE_W-1:0]      row_ratio,
  input  logic [snne_pkg::SCALE_W-1:0]      col_ratio,
  input  logic [snne_pkg::INDEX_BITS-1:0]   row_limit,
  input  logic [snne_pkg::INDEX_BITS-1:0]   col_limit,
  input  snne_pkg::qstat_t                  q_stat,
  output logic                              push,
  output snne_pkg::run_t                    push_data
);

  localparam logic [1:0] FS_IDLE  = 2'd0;
  localparam logic [1:0] FS_MUL   = 2'd1;
  localparam logic [1:0] FS_CLAMP = 2'd2;
  localparam logic [1:0] FS_COUNT = 2'd3;

  localparam int IB = snne_pkg::INDEX_BITS;
  localparam int PW = snne_pkg::PROD_W;
  localparam int CW = snne_pkg::CEIL_W;
  localparam int NW = snne_pkg::CNT_W;
  localparam int SW = snne_pkg::SCALE_W;

  logic [1:0]                     state;
  logic [IB-1:0]                  src_row;
  logic [IB-1:0]                  src_col;
  logic [snne_pkg::VALUE_W-1:0]   value;
  logic                           row_zero;
  logic                           col_zero;
  logic [PW-1:0]                  prod_ra;
  logic [PW-1:0]                  prod_rb;
  logic [PW-1:0]                  prod_ca;
  logic [PW-1:0]                  prod_cb;
  logic [IB-1:0]                  row_a;
  logic [IB-1:0]                  row_b;
  logic [IB-1:0]                  col_a;
  logic [IB-1:0]                  col_b;
  logic [NW-1:0]                  row_cnt;
  logic [NW-1:0]                  col_cnt;
  logic                           value_zero;

  // Ceiling of prod / 2^(frac+1), clamped to the limit.
  function automatic logic [IB-1:0] ceil_clamp(input logic [PW-1:0] prod,
                                               input logic [IB-1:0] limit);
    logic [PW:0]   sum;
    logic [CW-1:0] c;
    sum = {1'b0, prod} + (PW+1)'((1 << (snne_pkg::SCALE_FRAC_BITS + 1)) - 1);
    c   = sum[PW:snne_pkg::SCALE_FRAC_BITS+1];
    return (c > CW'(limit)) ? limit : c[IB-1:0];
  endfunction

  // Widen an empty range to one cell within the limit, then cut a long one.
  function automatic logic [NW-1:0] span_cnt(input logic [IB-1:0] a,
                                             input logic [IB-1:0] b,
                                             input logic [IB-1:0] limit);
    logic [IB:0]   a1;
    logic [IB-1:0] bb;
    logic [IB-1:0] diff;
    a1 = {1'b0, a} + (IB+1)'(1);
    if (b <= a) begin
      bb = (a1 > {1'b0, limit}) ? limit : a1[IB-1:0];
    end else begin
      bb = b;
    end
    diff = bb - a;
    return (diff > IB'(snne_pkg::MAX_SPAN)) ? NW'(snne_pkg::MAX_SPAN) : diff[NW-1:0];
  endfunction

  assign value_zero    = (s_axis_tdata[snne_pkg::DATA_W-2:2*snne_pkg::FIELD_W] == '0);
  assign s_axis_tready = (state == FS_IDLE);

  assign row_cnt = span_cnt(row_a, row_b, row_limit);
  assign col_cnt = span_cnt(col_a, col_b, col_limit);

  // Push a non-empty run once the queue has room.
  assign push = (state == FS_COUNT) && !q_stat.full && (row_cnt != '0) && (col_cnt != '0);

  always_comb begin
    push_data.row_first = row_a;
    push_data.row_cnt   = row_cnt;
    push_data.col_first = col_a;
    push_data.col_cnt   = col_cnt;
    push_data.value     = value;
  end

  // Sequence: accept, multiply, clamp, count and push; a word with a zero value is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FS_IDLE;
    end else begin
      case (state)
        FS_IDLE: begin
          if (s_axis_tvalid && !value_zero) begin
            state <= FS_MUL;
          end
        end
        FS_MUL:   state <= FS_CLAMP;
        FS_CLAMP: state <= FS_COUNT;
        FS_COUNT: begin
          if (!q_stat.full) begin
            state <= FS_IDLE;
          end
        end
        default:  state <= FS_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (state == FS_IDLE && s_axis_tvalid) begin
      src_row <= s_axis_tdata[IB-1:0];
      src_col <= s_axis_tdata[snne_pkg::FIELD_W +: IB];
      value   <= s_axis_tdata[2*snne_pkg::FIELD_W +: snne_pkg::VALUE_W];
    end
    if (state == FS_MUL) begin
      // 2r-1 is {r-1, 1} and 2r+1 is {r, 1}; r = 0 takes start 0 below.
      row_zero <= (src_row == '0);
      col_zero <= (src_col == '0);
      prod_ra  <= {{SW{1'b0}}, src_row - IB'(1), 1'b1} * {{(IB+1){1'b0}}, row_ratio};
      prod_rb  <= {{SW{1'b0}}, src_row, 1'b1} * {{(IB+1){1'b0}}, row_ratio};
      prod_ca  <= {{SW{1'b0}}, src_col - IB'(1), 1'b1} * {{(IB+1){1'b0}}, col_ratio};
      prod_cb  <= {{SW{1'b0}}, src_col, 1'b1} * {{(IB+1){1'b0}}, col_ratio};
    end
    if (state == FS_CLAMP) begin
      row_a <= row_zero ? '0 : ceil_clamp(prod_ra, row_limit);
      row_b <= ceil_clamp(prod_rb, row_limit);
      col_a <= col_zero ? '0 : ceil_clamp(prod_ca, col_limit);
      col_b <= ceil_clamp(prod_cb, col_limit);
    end
  end

endmodule

// ===== sv/snne_queue.sv =====
module snne_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  snne_pkg::run_t   push_data,
  input  logic             pop,
  output snne_pkg::run_t   pop_data,
  output snne_pkg::qstat_t q_stat
);

  localparam int QW = snne_pkg::QPTR_W;
  localparam int CW = snne_pkg::QCNT_W;

  snne_pkg::run_t  entries [snne_pkg::QUEUE_DEPTH];
  logic [QW-1:0]   wr_ptr;
  logic [QW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign q_stat.full  = (count == CW'(snne_pkg::QUEUE_DEPTH));
  assign q_stat.empty = (count == '0);
  assign pop_data     = entries[rd_ptr];

  // Advance pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QW'(snne_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QW'(snne_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  // Store pushed runs.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== sv/snne_back.sv =====
module snne_back (
  input  logic                        clk,
  input  logic                        rst,
  input  snne_pkg::qstat_t            q_stat,
  input  snne_pkg::run_t              pop_data,
  output logic                        pop,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [snne_pkg::DATA_W-1:0] m_axis_tdata,
  output logic                        m_axis_tlast
);

  localparam int NW = snne_pkg::CNT_W;
  localparam int IB = snne_pkg::INDEX_BITS;

  logic           active;
  snne_pkg::run_t run;
  logic [NW-1:0]  row_ofs;
  logic [NW-1:0]  col_ofs;
  logic           out_free;
  logic           emit;
  logic           last_col;
  logic           last_row;
  logic           last;
  logic [IB-1:0]  cell_row;
  logic [IB-1:0]  cell_col;

  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign emit     = active && out_free;
  assign last_col = (col_ofs == run.col_cnt - NW'(1));
  assign last_row = (row_ofs == run.row_cnt - NW'(1));
  assign last     = last_col && last_row;
  assign cell_row = run.row_first + IB'(row_ofs);
  assign cell_col = run.col_first + IB'(col_ofs);

  // Take the next run when idle or on the last cell of the current one.
  assign pop = !q_stat.empty && (!active || (emit && last));

  // Run control and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      active        <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (out_free) begin
        m_axis_tvalid <= emit;
      end
      if (pop) begin
        active <= 1'b1;
      end else if (emit && last) begin
        active <= 1'b0;
      end
    end
  end

  // Walk the run row-major and load the output word.
  always_ff @(posedge clk) begin
    if (pop) begin
      run     <= pop_data;
      row_ofs <= '0;
      col_ofs <= '0;
    end else if (emit) begin
      if (last_col) begin
        col_ofs <= '0;
        row_ofs <= row_ofs + NW'(1);
      end else begin
        col_ofs <= col_ofs + NW'(1);
      end
    end
    if (emit) begin
      m_axis_tdata <= {run.value, snne_pkg::FIELD_W'(cell_col), snne_pkg::FIELD_W'(cell_row)};
      m_axis_tlast <= last;
    end
  end

endmodule

// ===== sv/sparse_nearest_neighbor_expand.sv =====
// Channel | Direction | Data layout (lowest bits first)                 | Side band
// s_axis  | in        | src_row[31:0], src_col[63:32], entry_value[127:64] | none
// m_axis  | out       | dst_row[31:0], dst_col[63:32], value_out[127:64]   | tlast = last_of_run
// cfg     | in        | cfg_index selects, cfg_data[31:0] written on cfg_we | none
//
// The front steps through accept, multiply, clamp and count for each input word, holding
// in count while the queue is full; a word whose value is +0 or -0 is accepted and dropped.
// The back sends one destination cell per cycle while the output is not stalled; the
// sustained input rate is set by the front sequencer and the single output register.
// A two-entry run queue lets the sides stall apart.
// Reset is synchronous; it clears control state and loads register defaults.
module sparse_nearest_neighbor_expand (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // src_row, src_col, entry_value
  input  logic [snne_pkg::DATA_W-1:0]       s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // dst_row, dst_col, value_out
  output logic [snne_pkg::DATA_W-1:0]       m_axis_tdata,
  output logic                              m_axis_tlast,
  input  logic                              cfg_we,
  input  logic [snne_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [snne_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic [snne_pkg::SCALE_W-1:0]    row_scale_q16;
  logic [snne_pkg::SCALE_W-1:0]    col_scale_q16;
  logic [snne_pkg::CFG_DATA_W-1:0] out_rows;
  logic [snne_pkg::CFG_DATA_W-1:0] out_cols;

  logic             push;
  logic             pop;
  snne_pkg::run_t   push_data;
  snne_pkg::run_t   pop_data;
  snne_pkg::qstat_t q_stat;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_scale_q16 <= snne_pkg::SCALE_RESET;
      col_scale_q16 <= snne_pkg::SCALE_RESET;
      out_rows      <= snne_pkg::SIZE_RESET;
      out_cols      <= snne_pkg::SIZE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        snne_pkg::CFG_ROW_SCALE: row_scale_q16 <= cfg_data[snne_pkg::SCALE_W-1:0];
        snne_pkg::CFG_COL_SCALE: col_scale_q16 <= cfg_data[snne_pkg::SCALE_W-1:0];
        snne_pkg::CFG_OUT_ROWS:  out_rows      <= cfg_data;
        snne_pkg::CFG_OUT_COLS:  out_cols      <= cfg_data;
        default: ;
      endcase
    end
  end

  snne_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .row_ratio     (row_scale_q16),
    .col_ratio     (col_scale_q16),
    .row_limit     (out_rows[snne_pkg::INDEX_BITS-1:0]),
    .col_limit     (out_cols[snne_pkg::INDEX_BITS-1:0]),
    .q_stat        (q_stat),
    .push          (push),
    .push_data     (push_data)
  );

  snne_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_stat    (q_stat)
  );

  snne_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_stat        (q_stat),
    .pop_data      (pop_data),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// ===== sv/snne_checker.sv =====
`include "sparse_nearest_neighbor_expand_macros.svh"

module snne_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic [snne_pkg::DATA_W-1:0]       s_axis_tdata,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [snne_pkg::DATA_W-1:0]       m_axis_tdata,
  input logic                              m_axis_tlast
);

  logic in_word;
  logic in_nonzero;
  logic out_stall;

  assign in_word    = s_axis_tvalid && s_axis_tready;
  assign in_nonzero = (s_axis_tdata[snne_pkg::DATA_W-2:2*snne_pkg::FIELD_W] != '0);
  assign out_stall  = m_axis_tvalid && !m_axis_tready;

  // Reset leaves the output empty and the input open.
  `SNNE_ASSERT_NEXT_ALWAYS(a_rst_out_idle, clk, rst, !m_axis_tvalid, "output valid after reset")
  `SNNE_ASSERT_NEXT_ALWAYS(a_rst_in_open, clk, rst, s_axis_tready, "input not ready after reset")

  // A nonzero word occupies the front for the following cycle.
  `SNNE_ASSERT_NEXT(a_busy_after_word, clk, rst, in_word && in_nonzero,
                    !s_axis_tready, "front took two words back to back")

  // A stalled output word holds.
  `SNNE_ASSERT_NEXT(a_out_hold, clk, rst, out_stall,
                    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast),
                    "stalled output word changed")

endmodule

bind sparse_nearest_neighbor_expand snne_checker u_snne_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
